>>> src/lintp_pkg.sv
// ----------------------------------------------------------------------------
// lintp_pkg
// Shared types and constants of the LIN transport-layer response reassembler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lintp_pkg;

  // Input operation codes, carried in the slave-side tuser.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Result kinds, carried in the master-side tuser.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_SUCCESS = 2'd1;
  localparam logic [1:0] KIND_ABORT   = 2'd2;
  localparam logic [1:0] KIND_FAIL    = 2'd3;

  // PCI frame types (high nibble).
  localparam logic [3:0] PCI_SINGLE = 4'd0;
  localparam logic [3:0] PCI_FIRST  = 4'd1;
  localparam logic [3:0] PCI_CONSEC = 4'd2;

  localparam logic [7:0]  BCAST_NAD     = 8'd127;
  localparam logic [15:0] TIMEOUT_RESET = 16'd50;
  localparam logic [11:0] SF_MAX_LEN    = 12'd6;

  // Configuration register indexes.
  localparam logic REG_TIMEOUT = 1'b0;

  // Reception phase of the protocol.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_CONS
  } phase_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;   // capture the incoming request
    logic eval;  // apply the request to the protocol state and plan results
    logic load;  // move the next planned result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pending;    // at least one planned result not yet loaded
    logic final_one;  // the next result to load is the last one
    logic out_free;   // output register can take a result this cycle
  } status_t;

endpackage

`default_nettype wire

>>> src/lin_tp_reassembler_unit.sv
// ----------------------------------------------------------------------------
// lin_tp_reassembler_unit
// LIN diagnostic transport-layer receiver: reassembles response frames.
// ----------------------------------------------------------------------------
// Each request (start, received frame or millisecond tick) is taken one at a
// time: it is accepted in ST_IDLE, evaluated against the protocol state in
// ST_EVAL, then its results are loaded one per cycle in ST_EMIT while the
// output side is ready. A frame yields up to six payload bytes and a status.
// The pace is set by the single output register, which moves one result per
// cycle when not stalled. The next request is accepted as soon as its
// predecessor's last result sits in that register.
// The timeout register lies at byte address 0 of the APB port.
`timescale 1ns / 1ps
`default_nettype none

module lin_tp_reassembler_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata: req_nad[7:0], req_new_nad[15:8], frame_nad[23:16],
  //          frame_pci[31:24], frame_data[79:32]
  input  wire logic [79:0] s_tdata,
  // s_tuser: op[1:0]
  input  wire logic [1:0]  s_tuser,
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata: data_byte[7:0], byte_index[19:8], result_nad[27:20], zero[31:28]
  output logic [31:0]      m_tdata,
  // m_tuser: kind[1:0]
  output logic [1:0]       m_tuser,
  output logic             m_tlast,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  lintp_pkg::cmd_t    cmd;
  lintp_pkg::status_t sts;
  logic [15:0]        timeout_ticks;
  logic               reg_idx;

  // Register decode: one 32-bit register per word.
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= lintp_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (reg_idx == lintp_pkg::REG_TIMEOUT)) begin
      timeout_ticks <= pwdata[15:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      lintp_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_ticks};
      default:                prdata = 32'd0;
    endcase
  end

  lintp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lintp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .timeout_ticks (timeout_ticks),
    .in_op         (s_tuser),
    .in_data       (s_tdata),
    .cmd           (cmd),
    .sts           (sts),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast)
  );

endmodule

`default_nettype wire

>>> src/lintp_ctrl.sv
// ----------------------------------------------------------------------------
// lintp_ctrl
// Controller: accepts one request, has it evaluated, then sequences results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lintp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire lintp_pkg::status_t sts,
  output lintp_pkg::cmd_t        cmd
);

  lintp_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lintp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      lintp_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = lintp_pkg::ST_EVAL;
      end
      lintp_pkg::ST_EVAL: begin
        state_next = lintp_pkg::ST_EMIT;
      end
      lintp_pkg::ST_EMIT: begin
        if (!sts.pending) begin
          state_next = lintp_pkg::ST_IDLE;
        end else if (sts.out_free && sts.final_one) begin
          state_next = lintp_pkg::ST_IDLE;
        end
      end
      default: state_next = lintp_pkg::ST_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    unique case (state)
      lintp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.cap  = s_tvalid;
      end
      lintp_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      lintp_pkg::ST_EMIT: begin
        cmd.load = sts.pending && sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> src/lintp_datapath.sv
// ----------------------------------------------------------------------------
// lintp_datapath
// Protocol state, request capture, result planning and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lintp_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [15:0]        timeout_ticks,
  input  wire logic [1:0]         in_op,
  input  wire logic [79:0]        in_data,
  input  wire lintp_pkg::cmd_t    cmd,
  output lintp_pkg::status_t      sts,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [31:0]             m_tdata,
  output logic [1:0]              m_tuser,
  output logic                    m_tlast
);

  // Captured request.
  logic [1:0]  op;
  logic [7:0]  req_nad;
  logic [7:0]  req_new_nad;
  logic [7:0]  frame_nad;
  logic [7:0]  frame_pci;
  logic [47:0] frame_data;

  // Protocol state.
  lintp_pkg::phase_t phase, phase_next;
  logic [7:0]  accepted_nad, accepted_nad_next;
  logic [7:0]  expected_nad, expected_nad_next;
  logic [7:0]  changed_nad, changed_nad_next;
  logic [11:0] announced_len, announced_len_next;
  logic [11:0] received_len, received_len_next;
  logic [3:0]  seq_count, seq_count_next;
  logic [15:0] ticks_left, ticks_left_next;

  // Result plan.
  logic [47:0] emit_data, emit_data_next;
  logic [2:0]  emit_left, emit_left_next;
  logic [11:0] emit_idx, emit_idx_next;
  logic        st_pending, st_pending_next;
  logic [1:0]  st_kind, st_kind_next;
  logic [7:0]  st_nad, st_nad_next;

  // Evaluation helpers.
  logic [3:0]  frame_type;
  logic [3:0]  pci_low;
  logic [7:0]  acc_upd;
  logic [7:0]  succ_nad;
  logic [11:0] ff_len;
  logic [11:0] remain;
  logic [2:0]  take;
  logic [11:0] rec_sum;
  logic [16:0] tick_sum;

  assign frame_type = frame_pci[7:4];
  assign pci_low    = frame_pci[3:0];
  assign ff_len     = {pci_low, frame_data[47:40]};
  assign remain     = announced_len - received_len;
  assign take       = (remain < 12'd6) ? remain[2:0] : 3'd6;
  assign rec_sum    = received_len + {9'd0, take};
  assign tick_sum   = {1'b0, ticks_left} + {1'b0, timeout_ticks};

  // Address the waiting phase would accept this frame under.
  assign acc_upd = ((accepted_nad == lintp_pkg::BCAST_NAD) || (frame_nad == changed_nad))
                   ? frame_nad : accepted_nad;

  // Address reported on success, taken after the accepted address is updated.
  always_comb begin
    logic [7:0] acc_now;
    acc_now = (phase == lintp_pkg::PH_WAIT) ? acc_upd : accepted_nad;
    if ((expected_nad == lintp_pkg::BCAST_NAD) || (changed_nad != 8'd0)) begin
      succ_nad = acc_now;
    end else begin
      succ_nad = expected_nad;
    end
  end

  // Request evaluation: next protocol state and the plan of results.
  always_comb begin
    phase_next         = phase;
    accepted_nad_next  = accepted_nad;
    expected_nad_next  = expected_nad;
    changed_nad_next   = changed_nad;
    announced_len_next = announced_len;
    received_len_next  = received_len;
    seq_count_next     = seq_count;
    ticks_left_next    = ticks_left;
    emit_data_next     = frame_data;
    emit_left_next     = 3'd0;
    emit_idx_next      = 12'd0;
    st_pending_next    = 1'b0;
    st_kind_next       = lintp_pkg::KIND_FAIL;
    st_nad_next        = expected_nad;

    case (op)
      lintp_pkg::OP_START: begin
        expected_nad_next  = req_nad;
        accepted_nad_next  = req_nad;
        changed_nad_next   = req_new_nad;
        announced_len_next = 12'd0;
        received_len_next  = 12'd0;
        seq_count_next     = 4'd0;
        ticks_left_next    = timeout_ticks;
        phase_next         = lintp_pkg::PH_WAIT;
      end
      lintp_pkg::OP_TICK: begin
        if (phase != lintp_pkg::PH_IDLE) begin
          if (ticks_left <= 16'd1) begin
            ticks_left_next = 16'd0;
            phase_next      = lintp_pkg::PH_IDLE;
            st_pending_next = 1'b1;
          end else begin
            ticks_left_next = ticks_left - 16'd1;
          end
        end
      end
      lintp_pkg::OP_FRAME: begin
        if (phase == lintp_pkg::PH_WAIT) begin
          accepted_nad_next = acc_upd;
          if (acc_upd == frame_nad) begin
            if ((frame_type == lintp_pkg::PCI_SINGLE) &&
                ({8'd0, pci_low} <= lintp_pkg::SF_MAX_LEN)) begin
              // Single frame: its bytes, then success or failure when empty.
              emit_left_next  = pci_low[2:0];
              phase_next      = lintp_pkg::PH_IDLE;
              st_pending_next = 1'b1;
              if (pci_low == 4'd0) begin
                st_kind_next = lintp_pkg::KIND_FAIL;
                st_nad_next  = expected_nad;
              end else begin
                st_kind_next = lintp_pkg::KIND_SUCCESS;
                st_nad_next  = succ_nad;
              end
            end else if ((frame_type == lintp_pkg::PCI_FIRST) &&
                         (ff_len > lintp_pkg::SF_MAX_LEN)) begin
              // First frame: five bytes after the length byte, no status yet.
              announced_len_next = ff_len;
              emit_data_next     = {frame_data[39:0], 8'd0};
              emit_left_next     = 3'd5;
              received_len_next  = 12'd5;
              seq_count_next     = 4'd1;
              ticks_left_next    = timeout_ticks;
              phase_next         = lintp_pkg::PH_CONS;
            end else begin
              accepted_nad_next = expected_nad;
            end
          end
        end else if (phase == lintp_pkg::PH_CONS) begin
          if ((frame_nad != accepted_nad) || (frame_type != lintp_pkg::PCI_CONSEC) ||
              (pci_low != seq_count)) begin
            phase_next      = lintp_pkg::PH_IDLE;
            st_pending_next = 1'b1;
            st_kind_next    = lintp_pkg::KIND_ABORT;
            st_nad_next     = expected_nad;
          end else begin
            emit_left_next    = take;
            emit_idx_next     = received_len;
            received_len_next = rec_sum;
            seq_count_next    = seq_count + 4'd1;
            ticks_left_next   = tick_sum[16] ? 16'hFFFF : tick_sum[15:0];
            if (rec_sum == announced_len) begin
              phase_next      = lintp_pkg::PH_IDLE;
              st_pending_next = 1'b1;
              st_kind_next    = lintp_pkg::KIND_SUCCESS;
              st_nad_next     = succ_nad;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Status toward the controller.
  assign sts.pending   = (emit_left != 3'd0) || st_pending;
  assign sts.final_one = ((emit_left == 3'd1) && !st_pending) ||
                         ((emit_left == 3'd0) && st_pending);
  assign sts.out_free  = !m_tvalid || m_tready;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op          <= in_op;
      req_nad     <= in_data[7:0];
      req_new_nad <= in_data[15:8];
      frame_nad   <= in_data[23:16];
      frame_pci   <= in_data[31:24];
      frame_data  <= in_data[79:32];
    end
  end

  // Protocol state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= lintp_pkg::PH_IDLE;
      accepted_nad  <= 8'd0;
      expected_nad  <= 8'd0;
      changed_nad   <= 8'd0;
      announced_len <= 12'd0;
      received_len  <= 12'd0;
      seq_count     <= 4'd0;
      ticks_left    <= 16'd0;
    end else if (cmd.eval) begin
      phase         <= phase_next;
      accepted_nad  <= accepted_nad_next;
      expected_nad  <= expected_nad_next;
      changed_nad   <= changed_nad_next;
      announced_len <= announced_len_next;
      received_len  <= received_len_next;
      seq_count     <= seq_count_next;
      ticks_left    <= ticks_left_next;
    end
  end

  // Result plan: loaded on evaluation, consumed one result per load.
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_left  <= 3'd0;
      st_pending <= 1'b0;
    end else if (cmd.eval) begin
      emit_left  <= emit_left_next;
      st_pending <= st_pending_next;
    end else if (cmd.load) begin
      if (emit_left != 3'd0) begin
        emit_left <= emit_left - 3'd1;
      end else begin
        st_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      emit_data <= emit_data_next;
      emit_idx  <= emit_idx_next;
      st_kind   <= st_kind_next;
      st_nad    <= st_nad_next;
    end else if (cmd.load && (emit_left != 3'd0)) begin
      emit_data <= {emit_data[39:0], 8'd0};
      emit_idx  <= emit_idx + 12'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tlast <= sts.final_one;
      if (emit_left != 3'd0) begin
        m_tuser <= lintp_pkg::KIND_PAYLOAD;
        m_tdata <= {4'd0, 8'd0, emit_idx, emit_data[47:40]};
      end else begin
        m_tuser <= st_kind;
        m_tdata <= {4'd0, st_nad, 12'd0, 8'd0};
      end
    end
  end

`ifndef SYNTHESIS
  // While consecutive frames are expected, the message is never yet complete.
  assert property (@(posedge clk) disable iff (rst)
    (phase == lintp_pkg::PH_CONS) |-> (received_len < announced_len))
    else $error("consecutive phase with complete message");

  // A multi-frame message always announces more than a single frame holds.
  assert property (@(posedge clk) disable iff (rst)
    (phase == lintp_pkg::PH_CONS) |-> (announced_len > lintp_pkg::SF_MAX_LEN))
    else $error("consecutive phase with short announced length");

  // A result is only loaded into a free output register.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a waiting result");

  // A new request is only captured after all results of the last one are loaded.
  assert property (@(posedge clk) disable iff (rst)
    cmd.cap |-> !sts.pending)
    else $error("request captured with results outstanding");
`endif

endmodule

`default_nettype wire
